### design/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared widths, reset values and register codes of the velocity ramp planner.
// ----------------------------------------------------------------------------
package vrp_pkg;

    // Signed Q8.8 velocity word and unsigned Q7.8 step word.
    localparam int VEL_W  = 16;
    localparam int STEP_W = 15;

    // Both steps come out of reset at 2.0 in Q7.8.
    localparam logic [STEP_W-1:0] INCREASE_STEP_RESET = 15'd512;
    localparam logic [STEP_W-1:0] DECREASE_STEP_RESET = 15'd512;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_INCREASE_STEP = 1'b0,
        REG_DECREASE_STEP = 1'b1
    } cfg_reg_t;

endpackage

### design/vrp_if.sv
// ----------------------------------------------------------------------------
// vrp_if
// Valid/ready channels of the velocity ramp planner: target and planned beats.
// ----------------------------------------------------------------------------
interface vrp_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [vrp_pkg::VEL_W-1:0] target_vx;
    logic signed [vrp_pkg::VEL_W-1:0] target_vy;

    modport source (output valid, output target_vx, output target_vy, input ready);
    modport sink   (input valid, input target_vx, input target_vy, output ready);
endinterface

interface vrp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [vrp_pkg::VEL_W-1:0] planned_vx_out;
    logic signed [vrp_pkg::VEL_W-1:0] planned_vy_out;

    modport source (output valid, output planned_vx_out, output planned_vy_out, input ready);
    modport sink   (input valid, input planned_vx_out, input planned_vy_out, output ready);
endinterface

### design/vrp_axis.sv
// ----------------------------------------------------------------------------
// vrp_axis
// One-axis asymmetric slew limiter: next planned velocity from target and step.
// ----------------------------------------------------------------------------
module vrp_axis (
    input  logic signed [vrp_pkg::VEL_W-1:0]  target,
    input  logic signed [vrp_pkg::VEL_W-1:0]  planned,
    input  logic        [vrp_pkg::STEP_W-1:0] inc_step,
    input  logic        [vrp_pkg::STEP_W-1:0] dec_step,
    output logic signed [vrp_pkg::VEL_W-1:0]  planned_next
);

    localparam int EXT_W = vrp_pkg::VEL_W + 1;
    localparam int PAD_W = EXT_W - vrp_pkg::STEP_W;

    logic signed [EXT_W-1:0] t_ext;
    logic signed [EXT_W-1:0] p_ext;
    logic signed [EXT_W-1:0] inc_ext;
    logic signed [EXT_W-1:0] dec_ext;
    logic signed [EXT_W-1:0] mag_t;
    logic signed [EXT_W-1:0] mag_p;
    logic signed [EXT_W-1:0] sum;
    logic                    t_neg;
    logic                    p_neg;
    logic                    opposite;
    logic                    accel;

    always_comb
    begin
        t_neg   = target[vrp_pkg::VEL_W-1];
        p_neg   = planned[vrp_pkg::VEL_W-1];
        t_ext   = {t_neg, target};
        p_ext   = {p_neg, planned};
        inc_ext = {{PAD_W{1'b0}}, inc_step};
        dec_ext = {{PAD_W{1'b0}}, dec_step};
        mag_t   = t_neg ? -t_ext : t_ext;
        mag_p   = p_neg ? -p_ext : p_ext;

        // Strictly opposite signs; a zero on either side never counts.
        opposite = (!t_neg && (target != '0) && p_neg) ||
                   (t_neg && !p_neg && (planned != '0));
        accel    = !opposite && (mag_t >= mag_p);

        if (accel)
        begin
            if (!t_neg)
            begin
                sum = p_ext + inc_ext;
                if (sum > t_ext)
                    sum = t_ext;
            end
            else
            begin
                sum = p_ext - inc_ext;
                if (sum < t_ext)
                    sum = t_ext;
            end
        end
        else
        begin
            if (!p_neg)
            begin
                sum = p_ext - dec_ext;
                if (sum < t_ext)
                    sum = t_ext;
            end
            else
            begin
                sum = p_ext + dec_ext;
                if (sum > t_ext)
                    sum = t_ext;
            end
        end

        // The clamp to the target keeps the sum inside the 16-bit range.
        planned_next = sum[vrp_pkg::VEL_W-1:0];
    end

endmodule

### design/velocity_ramp_planner_top.sv
// ----------------------------------------------------------------------------
// velocity_ramp_planner_top
// Two-axis asymmetric velocity ramp: one planned-velocity beat per target beat.
// ----------------------------------------------------------------------------
// Every target beat produces exactly one result beat holding the planned X and
// Y velocities after one ramp step. The block sustains one beat per clock
// while the result channel is ready: a target beat is captured in an input
// register, the ramp step for both axes is a single add, compare and clamp
// per axis evaluated against the stored planned velocities, and the result is
// registered in an output register as the captured beat moves on. The planned
// velocities feed straight back into the next step, so consecutive beats use
// each other's results with no bubble between them. Backpressure on the result
// channel stalls the pipeline in place; the input side keeps accepting while a
// free register remains. The step registers are written through the cfg port
// and should only change while no beat is in flight. Both planned velocities
// reset to zero and both steps reset to 2.0.
// ----------------------------------------------------------------------------
module velocity_ramp_planner_top (
    input  logic                                clk,
    input  logic                                rst_n,
    vrp_in_if.sink                              in_ch,
    vrp_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  vrp_pkg::cfg_reg_t                   cfg_index,
    input  logic [vrp_pkg::STEP_W-1:0]          cfg_wdata
);

    // Step registers.
    logic [vrp_pkg::STEP_W-1:0] inc_step_reg;
    logic [vrp_pkg::STEP_W-1:0] dec_step_reg;

    // Input stage.
    logic                             s1_valid_reg;
    logic signed [vrp_pkg::VEL_W-1:0] s1_tx_reg;
    logic signed [vrp_pkg::VEL_W-1:0] s1_ty_reg;

    // Planned velocity state and its next value.
    logic signed [vrp_pkg::VEL_W-1:0] planned_vx_reg;
    logic signed [vrp_pkg::VEL_W-1:0] planned_vy_reg;
    logic signed [vrp_pkg::VEL_W-1:0] planned_vx_next;
    logic signed [vrp_pkg::VEL_W-1:0] planned_vy_next;

    // Output stage.
    logic                             out_valid_reg;
    logic signed [vrp_pkg::VEL_W-1:0] out_vx_reg;
    logic signed [vrp_pkg::VEL_W-1:0] out_vy_reg;

    logic out_load;
    logic s1_load;

    // The output register can take a new result when it is empty or its
    // current beat leaves this cycle. The input register loads when it is empty or the output register does.
    assign out_load    = !out_valid_reg || out_ch.ready;
    assign s1_load     = !s1_valid_reg || out_load;
    assign in_ch.ready = s1_load;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_step_reg <= vrp_pkg::INCREASE_STEP_RESET;
            dec_step_reg <= vrp_pkg::DECREASE_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vrp_pkg::REG_INCREASE_STEP: inc_step_reg <= cfg_wdata;
                vrp_pkg::REG_DECREASE_STEP: dec_step_reg <= cfg_wdata;
            endcase
        end
    end

    // One ramp unit per axis, both driven by the captured target beat.
    vrp_axis u_axis_x (
        .target       (s1_tx_reg),
        .planned      (planned_vx_reg),
        .inc_step     (inc_step_reg),
        .dec_step     (dec_step_reg),
        .planned_next (planned_vx_next)
    );

    vrp_axis u_axis_y (
        .target       (s1_ty_reg),
        .planned      (planned_vy_reg),
        .inc_step     (inc_step_reg),
        .dec_step     (dec_step_reg),
        .planned_next (planned_vy_next)
    );

    // Control state: valid flags and the planned velocities. The state only
    // advances when the captured beat is handed to the output register, so a
    // stalled beat is never stepped twice.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            planned_vx_reg <= '0;
            planned_vy_reg <= '0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_ch.valid;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
            if (out_load && s1_valid_reg)
            begin
                planned_vx_reg <= planned_vx_next;
                planned_vy_reg <= planned_vy_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s1_load && in_ch.valid)
        begin
            s1_tx_reg <= in_ch.target_vx;
            s1_ty_reg <= in_ch.target_vy;
        end
        if (out_load && s1_valid_reg)
        begin
            out_vx_reg <= planned_vx_next;
            out_vy_reg <= planned_vy_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.planned_vx_out = out_vx_reg;
    assign out_ch.planned_vy_out = out_vy_reg;

endmodule

### tb/sv/velocity_ramp_planner_checker.sv
// ----------------------------------------------------------------------------
// velocity_ramp_planner_checker
// Watches the target, planned and cfg ports, predicts every planned beat and
// compares it field by field with what the planner delivers.
// ----------------------------------------------------------------------------
module velocity_ramp_planner_checker
    import vrp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    vrp_in_if                   in_ch,
    vrp_out_if                  out_ch,
    input  logic                cfg_we,
    input  cfg_reg_t            cfg_index,
    input  logic [STEP_W-1:0]   cfg_wdata,
    output int                  mismatches,
    output int                  expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
    } velocity_pair_t;

    velocity_pair_t          planned_q[$];
    logic [STEP_W-1:0]       up_step;
    logic [STEP_W-1:0]       down_step;
    logic signed [VEL_W-1:0] plan_x;
    logic signed [VEL_W-1:0] plan_y;

    // One ramp step of one axis. Sums are kept at 17 bits so that the
    // magnitude of the most negative word and every step stay exact.
    function automatic logic signed [VEL_W-1:0] ramp_axis_step(
        input logic signed [VEL_W-1:0] target,
        input logic signed [VEL_W-1:0] planned,
        input logic [STEP_W-1:0]       rise,
        input logic [STEP_W-1:0]       fall
    );
        logic signed [VEL_W:0] t_ext;
        logic signed [VEL_W:0] p_ext;
        logic signed [VEL_W:0] t_mag;
        logic signed [VEL_W:0] p_mag;
        logic signed [VEL_W:0] next;
        logic                  opposite;
        t_ext    = target;
        p_ext    = planned;
        t_mag    = (t_ext < 0) ? -t_ext : t_ext;
        p_mag    = (p_ext < 0) ? -p_ext : p_ext;
        opposite = (t_ext > 0 && p_ext < 0) || (t_ext < 0 && p_ext > 0);
        if (!opposite && t_mag >= p_mag) begin
            if (t_ext >= 0) begin
                next = p_ext + $signed({2'b00, rise});
                if (next > t_ext) next = t_ext;
            end
            else begin
                next = p_ext - $signed({2'b00, rise});
                if (next < t_ext) next = t_ext;
            end
        end
        else begin
            if (p_ext >= 0) begin
                next = p_ext - $signed({2'b00, fall});
                if (next < t_ext) next = t_ext;
            end
            else begin
                next = p_ext + $signed({2'b00, fall});
                if (next > t_ext) next = t_ext;
            end
        end
        return next[VEL_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        velocity_pair_t want;
        if (!rst_n) begin
            planned_q.delete();
            up_step       = INCREASE_STEP_RESET;
            down_step     = DECREASE_STEP_RESET;
            plan_x        = '0;
            plan_y        = '0;
            mismatches    = 0;
            expected_left <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_INCREASE_STEP: up_step   = cfg_wdata;
                    REG_DECREASE_STEP: down_step = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                plan_x = ramp_axis_step(in_ch.target_vx, plan_x, up_step, down_step);
                plan_y = ramp_axis_step(in_ch.target_vy, plan_y, up_step, down_step);
                planned_q.push_back('{vx: plan_x, vy: plan_y});
            end
            if (out_ch.valid && out_ch.ready) begin
                if (planned_q.size() == 0) begin
                    $error("planned beat with no target beat pending: vx %0d vy %0d",
                           out_ch.planned_vx_out, out_ch.planned_vy_out);
                    mismatches++;
                end
                else begin
                    want = planned_q.pop_front();
                    if (out_ch.planned_vx_out !== want.vx) begin
                        $error("planned_vx_out: expected %0d, got %0d",
                               want.vx, out_ch.planned_vx_out);
                        mismatches++;
                    end
                    if (out_ch.planned_vy_out !== want.vy) begin
                        $error("planned_vy_out: expected %0d, got %0d",
                               want.vy, out_ch.planned_vy_out);
                        mismatches++;
                    end
                end
            end
            expected_left <= planned_q.size();
        end
    end

endmodule

### tb/sv/velocity_ramp_planner_top_test.sv
// ----------------------------------------------------------------------------
// velocity_ramp_planner_top_test
// Drives target beats and step settings into the planner and gives the verdict;
// the checker beside the block predicts and compares every planned beat.
// ----------------------------------------------------------------------------
module velocity_ramp_planner_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vrp_pkg::*;

    // Random part: this many phases, each with its own pair of steps.
    localparam int RANDOM_PHASES    = 8;
    localparam int BEATS_PER_PHASE  = 116;
    // The phase in which the result side holds off for a long stretch.
    localparam int PRESSURE_PHASE   = 3;
    localparam int LONG_HOLD_CYCLES = 160;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_reg_t          cfg_index;
    logic [STEP_W-1:0] cfg_wdata;
    int                mismatches;
    int                expected_left;

    // Handshake pacing. A "tight" side goes without idle cycles until it
    // flips back; the pressure request makes the receiver hold off once.
    bit tx_tight;
    bit rx_tight;
    bit tx_burst;
    bit long_hold_request;

    logic signed [VEL_W-1:0] last_vx;
    logic signed [VEL_W-1:0] last_vy;

    vrp_in_if  target_ch ();
    vrp_out_if planned_ch ();

    velocity_ramp_planner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (target_ch),
        .out_ch    (planned_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    velocity_ramp_planner_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (target_ch),
        .out_ch        (planned_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The timeout is over ten times the slowest honest run (both sides idling
    // their longest gap on every beat, plus the long hold and the drains).
    initial
    begin
        #5_000_000;
        $display("velocity_ramp_planner_top_test: errors");
        $finish;
    end

    // Offers one target beat and returns at the edge where it is taken.
    // Valid is only lowered when an idle gap is actually inserted, so a
    // back-to-back beat never sees valid dropped and raised in one step.
    task automatic send_target(input logic signed [VEL_W-1:0] vx,
                               input logic signed [VEL_W-1:0] vy);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_tight = !tx_tight;
        gap = (tx_tight || tx_burst) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            target_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        target_ch.valid     <= 1'b1;
        target_ch.target_vx <= vx;
        target_ch.target_vy <= vy;
        last_vx = vx;
        last_vy = vy;
        @(posedge clk);
        while (!target_ch.ready) @(posedge clk);
    endtask

    // Waits until every predicted beat has come back. Each target beat always
    // makes exactly one result, so an empty store means the pipeline is empty;
    // an extra wait covers the two-register path anyway.
    task automatic drain;
        target_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both step registers are written, one after the other, only while idle.
    task automatic write_steps(input logic [STEP_W-1:0] rise,
                               input logic [STEP_W-1:0] fall);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INCREASE_STEP;
        cfg_wdata <= rise;
        @(posedge clk);
        cfg_index <= REG_DECREASE_STEP;
        cfg_wdata <= fall;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Step settings lean toward the extremes and toward small steps, which
    // take many beats to reach a target and so exercise the clamp late.
    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return STEP_W'(1);
            3, 4, 5: return STEP_W'($urandom_range(1, 1023));
            default: return STEP_W'($urandom_range(0, 32767));
        endcase
    endfunction

    // Targets are held or small half of the time so that the planned value actually
    // catches up with them; the rest are zeros, extremes, sign flips and
    // full-range noise.
    function automatic logic signed [VEL_W-1:0] pick_target(
        input logic signed [VEL_W-1:0] last
    );
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3, 4: return last;
            5, 6:    return VEL_W'($urandom_range(0, 2047) - 1024);
            7:       return -last;
            default: return VEL_W'($urandom());
        endcase
    endfunction

    // Result side. Each beat gets its own wait; ready is only lowered when a
    // wait is inserted. The long hold is counted here, on its own, while the
    // sender keeps offering beats until the planner stops taking them.
    initial
    begin
        int gap;
        planned_ch.ready <= 1'b0;
        rx_tight = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_tight = !rx_tight;
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                gap = LONG_HOLD_CYCLES;
            end
            else begin
                gap = rx_tight ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                planned_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            planned_ch.ready <= 1'b1;
            @(posedge clk);
            while (!planned_ch.valid) @(posedge clk);
        end
    end

    // Stimulus: reset, a directed walk through the ramp rules, then random
    // phases each with fresh step settings, then the verdict.
    initial
    begin
        target_ch.valid     <= 1'b0;
        target_ch.target_vx <= '0;
        target_ch.target_vy <= '0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_INCREASE_STEP;
        cfg_wdata           <= '0;
        rst_n               <= 1'b0;
        tx_tight          = 1'b0;
        tx_burst          = 1'b0;
        long_hold_request = 1'b0;
        last_vx           = '0;
        last_vy           = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset steps of 2.0. Both zero first, then speeding up toward the
        // extremes, reversing, clamping at a nearby target, and slowing down
        // toward a smaller target of the same sign.
        send_target(16'sd0, 16'sd0);
        send_target(16'sh7FFF, 16'sh8000);
        send_target(16'sh7FFF, 16'sh8000);
        send_target(16'sh8000, 16'sh7FFF);
        send_target(16'sh8000, 16'sh7FFF);
        send_target(16'sh8000, 16'sh7FFF);
        send_target(16'sd0, 16'sd0);
        send_target(16'sd300, -16'sd300);
        send_target(16'sd100, -16'sd100);
        send_target(-16'sd1, 16'sd1);
        drain();

        // No increase at all and the largest decrease: a reversal jumps
        // almost the full range, then speeding up holds still.
        write_steps('0, '1);
        send_target(16'sh7FFF, 16'sh8000);
        send_target(16'sh7FFF, 16'sh8000);
        send_target(16'sh8000, 16'sh7FFF);
        send_target(16'sh8000, 16'sh7FFF);
        drain();

        // The largest increase reaches both ends of the word in one beat,
        // and with no decrease slowing down or reversing holds still.
        write_steps('1, '0);
        send_target(16'sh8000, 16'sh7FFF);
        send_target(16'sh7FFF, 16'sh8000);
        send_target(16'sd0, 16'sd0);
        drain();

        // The smallest nonzero steps, starting from the ends of the word.
        write_steps(STEP_W'(1), STEP_W'(1));
        send_target(16'sd0, 16'sd0);
        send_target(16'sh8000, 16'sh7FFF);
        send_target(16'sh7FFF, 16'sh8000);
        send_target(16'sh7FFF, 16'sh8000);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_steps(pick_step(), pick_step());
            if (phase == PRESSURE_PHASE) begin
                long_hold_request = 1'b1;
                tx_burst          = 1'b1;
            end
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                send_target(pick_target(last_vx), pick_target(last_vy));
                // Once the hold is over the pressure stretch has done its
                // job; normal pacing resumes.
                if (n == BEATS_PER_PHASE / 2) tx_burst = 1'b0;
            end
            drain();
        end

        // The drain above left the store empty; give any stray beat time to
        // show up before judging.
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_left == 0) begin
            $display("velocity_ramp_planner_top_test: clean");
        end
        else begin
            $display("velocity_ramp_planner_top_test: errors");
        end
        $finish;
    end

endmodule
